[src/ght_pkg.sv]
// ----------------------------------------------------------------------------
// ght_pkg
// Shared widths, operation and status codes, register indexes and the
// command bundle that runs between the handle table controller and datapath.
// ----------------------------------------------------------------------------
package ght_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 32;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);

    // field widths
    localparam int FUNC_W   = 3;
    localparam int IDX_W    = 10;
    localparam int ID_W     = 32;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 8;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_ACTIVATE   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INVALIDATE = 3'd1;
    localparam logic [FUNC_W-1:0] FN_CHECK      = 3'd2;
    localparam logic [FUNC_W-1:0] FN_ACQUIRE    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_RELEASE    = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_SUCCESS      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HANDLE_ERROR = 3'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_VALID        = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_MARKER = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ID     = 8'd1;

    // controller to datapath commands
    typedef struct packed {
        logic capture;    // load a new operation
        logic scan;       // register lookup and free slot search
        logic commit;     // update table and load result
        logic cfg_write;  // configuration transaction completes
    } ght_cmd_t;

endpackage

[src/ght_ctrl.sv]
// ----------------------------------------------------------------------------
// ght_ctrl
// Sequencer for the handle table: accepts commands, steps each through a
// scan cycle and a commit cycle, and raises the result strobe.
// ----------------------------------------------------------------------------
module ght_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              cfg_valid,
    output logic              busy,
    output logic              cfg_ready,
    output logic              done,
    output ght_pkg::ght_cmd_t cmd
);
    import ght_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   accept;

    // handshake decode
    assign busy      = (state_reg == S_SCAN);
    assign cfg_ready = (state_reg == S_IDLE);
    assign accept    = start && !busy;
    assign done      = done_reg;

    // commands to the datapath
    assign cmd.capture   = accept;
    assign cmd.scan      = (state_reg == S_SCAN);
    assign cmd.commit    = (state_reg == S_COMMIT);
    assign cmd.cfg_write = cfg_valid && cfg_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                state_next = accept ? S_SCAN : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_COMMIT);
        end
    end

endmodule

[src/ght_datapath.sv]
// ----------------------------------------------------------------------------
// ght_datapath
// Slot id table, pin bits, id counter and empty marker, with the lookup,
// free slot priority encode and result logic of the handle table.
// ----------------------------------------------------------------------------
module ght_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ght_pkg::ght_cmd_t                cmd,
    input  logic [ght_pkg::FUNC_W-1:0]       func,
    input  logic [ght_pkg::IDX_W-1:0]        slot_index,
    input  logic [ght_pkg::ID_W-1:0]         handle_id,
    input  logic [ght_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ght_pkg::ID_W-1:0]         cfg_data,
    output logic [ght_pkg::STATUS_W-1:0]     status,
    output logic [ght_pkg::ID_W-1:0]         issued_id,
    output logic [ght_pkg::IDX_W-1:0]        issued_slot
);
    import ght_pkg::*;

    localparam logic [IDX_W:0] IDX_LIMIT = (IDX_W + 1)'(TABLE_DEPTH);

    // table state
    logic [ID_W-1:0]        ids_reg [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [TABLE_DEPTH-1:0] valid_next;
    logic [TABLE_DEPTH-1:0] pinned_reg;
    logic [TABLE_DEPTH-1:0] pinned_next;
    logic [ID_W-1:0]        marker_reg;
    logic [ID_W-1:0]        counter_reg;

    // captured operation
    logic [FUNC_W-1:0] func_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [ID_W-1:0]   hid_reg;

    // scan results
    logic              found_reg;
    logic [SLOT_W-1:0] free_slot_reg;
    logic [ID_W-1:0]   new_id_reg;
    logic              match_reg;
    logic              pin_rd_reg;
    logic              in_range_reg;

    // result registers
    logic [STATUS_W-1:0] status_reg;
    logic [ID_W-1:0]     issued_id_reg;
    logic [IDX_W-1:0]    issued_slot_reg;

    // scan logic
    logic [TABLE_DEPTH-1:0] free_vec;
    logic                   found;
    logic [SLOT_W-1:0]      free_slot;
    logic [ID_W-1:0]        cand_id;
    logic [ID_W-1:0]        new_id;
    logic [SLOT_W-1:0]      rd_slot;
    logic [ID_W-1:0]        rd_id;
    logic                   in_range;

    // commit logic
    logic                act_hit;
    logic [STATUS_W-1:0] status_next;

    assign status      = status_reg;
    assign issued_id   = issued_id_reg;
    assign issued_slot = issued_slot_reg;

    // free slots: unpinned and holding the marker (unwritten slots read as marker)
    always_comb
    begin
        for (int k = 0; k < TABLE_DEPTH; k++)
            free_vec[k] = !pinned_reg[k] && (!valid_reg[k] || ids_reg[k] == marker_reg);
    end

    // lowest free slot
    always_comb
    begin
        found     = 1'b0;
        free_slot = '0;
        for (int k = TABLE_DEPTH - 1; k >= 0; k--)
        begin
            if (free_vec[k])
            begin
                found     = 1'b1;
                free_slot = SLOT_W'(k);
            end
        end
    end

    // next id, stepping over the marker
    assign cand_id = counter_reg + 32'd1;
    assign new_id  = (cand_id == marker_reg) ? cand_id + 32'd1 : cand_id;

    // handle lookup
    assign in_range = ({1'b0, idx_reg} < IDX_LIMIT);
    assign rd_slot  = idx_reg[SLOT_W-1:0];
    assign rd_id    = valid_reg[rd_slot] ? ids_reg[rd_slot] : marker_reg;

    // capture operation
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func;
            idx_reg  <= slot_index;
            hid_reg  <= handle_id;
        end
    end

    // scan stage registers
    always_ff @(posedge clk)
    begin
        if (cmd.scan)
        begin
            found_reg     <= found;
            free_slot_reg <= free_slot;
            new_id_reg    <= new_id;
            match_reg     <= (rd_id == hid_reg);
            pin_rd_reg    <= pinned_reg[rd_slot];
            in_range_reg  <= in_range;
        end
    end

    // operation decode and table bit updates
    always_comb
    begin
        act_hit     = (func_reg == FN_ACTIVATE) && found_reg;
        status_next = ST_HANDLE_ERROR;
        valid_next  = valid_reg;
        pinned_next = pinned_reg;
        if (cmd.cfg_write && cfg_index == CFG_EMPTY_MARKER)
        begin
            // live slots holding the old marker become empty
            for (int k = 0; k < TABLE_DEPTH; k++)
                if (valid_reg[k] && ids_reg[k] == marker_reg)
                    valid_next[k] = 1'b0;
        end
        unique case (func_reg)
            FN_ACTIVATE:
            begin
                status_next = found_reg ? ST_SUCCESS : ST_NO_SPACE;
                if (cmd.commit && found_reg)
                    valid_next[free_slot_reg] = 1'b1;
            end
            FN_INVALIDATE:
            begin
                if (in_range_reg)
                begin
                    status_next = ST_INVALID;
                    if (cmd.commit && match_reg)
                        valid_next[rd_slot] = 1'b0;
                end
            end
            FN_CHECK:
            begin
                if (in_range_reg)
                    status_next = match_reg ? ST_VALID : ST_INVALID;
            end
            FN_ACQUIRE:
            begin
                if (in_range_reg)
                begin
                    if (pin_rd_reg)
                        status_next = ST_HANDLE_ERROR;
                    else if (match_reg)
                    begin
                        status_next = ST_SUCCESS;
                        if (cmd.commit)
                            pinned_next[rd_slot] = 1'b1;
                    end
                    else
                        status_next = ST_INVALID;
                end
            end
            FN_RELEASE:
            begin
                if (in_range_reg)
                begin
                    status_next = ST_SUCCESS;
                    if (cmd.commit)
                        pinned_next[rd_slot] = 1'b0;
                end
            end
            default:
            begin
                status_next = ST_HANDLE_ERROR;
            end
        endcase
    end

    // valid and pin bits, marker, id counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            pinned_reg  <= '0;
            marker_reg  <= '0;
            counter_reg <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            pinned_reg <= pinned_next;
            if (cmd.cfg_write && cfg_index == CFG_EMPTY_MARKER)
                marker_reg <= cfg_data;
            if (cmd.cfg_write && cfg_index == CFG_FIRST_ID)
                counter_reg <= cfg_data;
            else if (cmd.commit && act_hit)
                counter_reg <= new_id_reg;
        end
    end

    // slot id storage
    always_ff @(posedge clk)
    begin
        if (cmd.commit && act_hit)
            ids_reg[free_slot_reg] <= new_id_reg;
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg      <= status_next;
            issued_id_reg   <= act_hit ? new_id_reg : '0;
            issued_slot_reg <= act_hit ? IDX_W'(free_slot_reg) : '0;
        end
    end

endmodule

[src/generational_handle_table_top.sv]
// ----------------------------------------------------------------------------
// generational_handle_table_top
// Table of slots holding generational ids and pin bits, with activate,
// invalidate, check, acquire and release operations on handles.
// ----------------------------------------------------------------------------
// Usage
// - command channel: drive func, slot_index and handle_id with start high;
//   the transaction is taken at a rising edge where start is high and busy
//   is low
// - every command gives one result: status, issued_id and issued_slot are
//   shown for exactly one cycle while done is high; the receiver cannot stall
// - done is registered from the commit state, so it rises once the commit state ends
// - each command passes a scan state (slot read, id compare, free slot priority
//   encode over the table) and a commit state (table and counter update); busy
//   is high only in the scan state, so the next command can be taken at the edge
//   that ends the commit state
// - configuration: cfg_index / cfg_data with cfg_valid and cfg_ready, taken
//   only while no command is in flight; index 0 sets the empty marker,
//   index 1 loads the id counter, other indexes are ignored
// - reset (rst_n low, asynchronous): all slots empty and unpinned, marker
//   and id counter zero; no clearing pass, commands are taken right away
// ----------------------------------------------------------------------------
module generational_handle_table_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ght_pkg::FUNC_W-1:0]        func,
    input  logic [ght_pkg::IDX_W-1:0]         slot_index,
    input  logic [ght_pkg::ID_W-1:0]          handle_id,
    output logic                              done,
    output logic [ght_pkg::STATUS_W-1:0]      status,
    output logic [ght_pkg::ID_W-1:0]          issued_id,
    output logic [ght_pkg::IDX_W-1:0]         issued_slot,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ght_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ght_pkg::ID_W-1:0]          cfg_data
);
    import ght_pkg::*;

    ght_cmd_t cmd;

    // sequencer
    ght_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cfg_valid (cfg_valid),
        .busy      (busy),
        .cfg_ready (cfg_ready),
        .done      (done),
        .cmd       (cmd)
    );

    // table and result datapath
    ght_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .func        (func),
        .slot_index  (slot_index),
        .handle_id   (handle_id),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .status      (status),
        .issued_id   (issued_id),
        .issued_slot (issued_slot)
    );

endmodule
